>>> sv/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

>>> sv/pgr_pkg.sv
// Shared constants for the prime gap range finder.
package pgr_pkg;
    localparam int WINDOW_SIZE_DEF      = 65536;
    localparam int BASE_LIMIT_DEF       = 46346;
    localparam int BASE_PRIME_COUNT_DEF = 4792;
    localparam int VAL_W                = 31;
    localparam int STAT_W               = 2;

    localparam logic [STAT_W-1:0] ST_PAIR = 2'd0;
    localparam logic [STAT_W-1:0] ST_FEW  = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;
endpackage

>>> sv/pgr_ram.sv
// Generic simple dual-port RAM with registered read.
module pgr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/prime_gap_range_finder.sv
// Prime gap range finder: segmented sieve over one query range per item.
// After reset the block clears a startup bitmap and sieves the base primes into a
// table; no item is accepted until that finishes. Each query then clears the window
// bitmap, one entry per value from low to high; for each base prime tried it finds
// the remainder of low with a bit-serial unit and strikes the odd multiples in the
// window; then it scans every value in the range. A reversed or too-wide range
// returns status 2 without sieving. One query is worked on at a time; the next may
// be accepted while the previous result waits at the output.
module prime_gap_range_finder #(
    parameter int WINDOW_SIZE      = pgr_pkg::WINDOW_SIZE_DEF,
    parameter int BASE_LIMIT       = pgr_pkg::BASE_LIMIT_DEF,
    parameter int BASE_PRIME_COUNT = pgr_pkg::BASE_PRIME_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [pgr_pkg::VAL_W-1:0]   i_range_low,
    input  logic [pgr_pkg::VAL_W-1:0]   i_range_high,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [pgr_pkg::STAT_W-1:0]  o_status,
    output logic [pgr_pkg::VAL_W-1:0]   o_close_first,
    output logic [pgr_pkg::VAL_W-1:0]   o_close_second,
    output logic [pgr_pkg::VAL_W-1:0]   o_far_first,
    output logic [pgr_pkg::VAL_W-1:0]   o_far_second
);
    import pgr_pkg::*;
`include "assert_macros.svh"

    localparam int CW    = $clog2(BASE_LIMIT + 1);
    localparam int TW    = $clog2(BASE_PRIME_COUNT);
    localparam int KW    = $clog2(BASE_PRIME_COUNT + 1);
    localparam int OFS_W = $clog2(WINDOW_SIZE);
    localparam int IW    = 17;
    localparam int JW    = 33;

    localparam logic [4:0] S_BCLR  = 5'd0;
    localparam logic [4:0] S_BINIT = 5'd1;
    localparam logic [4:0] S_BRD   = 5'd2;
    localparam logic [4:0] S_BEV   = 5'd3;
    localparam logic [4:0] S_BSQ   = 5'd4;
    localparam logic [4:0] S_BMARK = 5'd5;
    localparam logic [4:0] S_IDLE  = 5'd6;
    localparam logic [4:0] S_CLR   = 5'd7;
    localparam logic [4:0] S_KRD   = 5'd8;
    localparam logic [4:0] S_KEV   = 5'd9;
    localparam logic [4:0] S_KSQ   = 5'd10;
    localparam logic [4:0] S_KCHK  = 5'd11;
    localparam logic [4:0] S_DIV   = 5'd12;
    localparam logic [4:0] S_M0    = 5'd13;
    localparam logic [4:0] S_M1    = 5'd14;
    localparam logic [4:0] S_M2    = 5'd15;
    localparam logic [4:0] S_MARK  = 5'd16;
    localparam logic [4:0] S_SRD   = 5'd17;
    localparam logic [4:0] S_SEV   = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    logic [4:0]       r_state, n_state;
    logic [IW-1:0]    r_i, n_i;
    logic [JW-1:0]    r_j, n_j;
    logic [KW-1:0]    r_cnt, n_cnt;
    logic [KW-1:0]    r_k, n_k;
    logic [15:0]      r_p, n_p;
    logic [31:0]      r_psq, n_psq;
    logic [15:0]      r_rem, n_rem;
    logic [VAL_W-1:0] r_dq, n_dq;
    logic [4:0]       r_dcnt, n_dcnt;
    logic [JW-1:0]    r_m, n_m;
    logic [VAL_W-1:0] r_lo, n_lo;
    logic [VAL_W-1:0] r_hi, n_hi;
    logic [OFS_W-1:0] r_diff, n_diff;
    logic [OFS_W-1:0] r_ofs, n_ofs;
    logic [VAL_W-1:0] r_v, n_v;
    logic [VAL_W-1:0] r_prev, n_prev;
    logic             r_pvalid, n_pvalid;
    logic [VAL_W-1:0] r_sgap, n_sgap;
    logic [VAL_W-1:0] r_lgap, n_lgap;
    logic [VAL_W-1:0] r_cf, n_cf;
    logic [VAL_W-1:0] r_cs, n_cs;
    logic [VAL_W-1:0] r_ff, n_ff;
    logic [VAL_W-1:0] r_fs, n_fs;
    logic             r_pair, n_pair;
    logic             r_bad, n_bad;

    logic              r_o_valid, n_o_valid;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [VAL_W-1:0]  r_o_cf, n_o_cf;
    logic [VAL_W-1:0]  r_o_cs, n_o_cs;
    logic [VAL_W-1:0]  r_o_ff, n_o_ff;
    logic [VAL_W-1:0]  r_o_fs, n_o_fs;

    logic             comp_we, comp_wdata, comp_rdata;
    logic             tab_we;
    logic [TW-1:0]    tab_waddr;
    logic [15:0]      tab_wdata, tab_rdata;
    logic             win_we, win_wdata, win_rdata;
    logic [OFS_W-1:0] win_waddr, win_raddr;

    logic             in_acc;
    logic [31:0]      q_diff;
    logic [IW-1:0]    i_next;
    logic [KW-1:0]    k_next;
    logic [16:0]      div_t;
    logic             is_prime;
    logic [VAL_W-1:0] gap;
    logic [JW-1:0]    m_ofs;

    assign in_acc    = i_valid && !o_stall;
    assign q_diff    = {1'b0, i_range_high} - {1'b0, i_range_low};
    assign i_next    = r_i + IW'(2);
    assign k_next    = r_k + KW'(1);
    assign div_t     = {r_rem, r_dq[VAL_W-1]};
    assign gap       = r_v - r_prev;
    assign m_ofs     = r_m - JW'(r_lo);
    assign win_raddr = OFS_W'(r_v - r_lo);
    assign tab_waddr = (r_state == S_BINIT) ? '0 : r_cnt[TW-1:0];

    always_comb begin
        if (r_v == VAL_W'(2)) begin
            is_prime = 1'b1;
        end else if (r_v < VAL_W'(3) || !r_v[0]) begin
            is_prime = 1'b0;
        end else begin
            is_prime = !win_rdata;
        end
    end

    pgr_ram #(.WIDTH(1), .DEPTH(BASE_LIMIT + 1)) u_comp_ram (
        .i_clk   (i_clk),
        .i_we    (comp_we),
        .i_waddr (r_j[CW-1:0]),
        .i_wdata (comp_wdata),
        .i_raddr (r_i[CW-1:0]),
        .o_rdata (comp_rdata)
    );

    pgr_ram #(.WIDTH(16), .DEPTH(BASE_PRIME_COUNT)) u_tab_ram (
        .i_clk   (i_clk),
        .i_we    (tab_we),
        .i_waddr (tab_waddr),
        .i_wdata (tab_wdata),
        .i_raddr (r_k[TW-1:0]),
        .o_rdata (tab_rdata)
    );

    pgr_ram #(.WIDTH(1), .DEPTH(WINDOW_SIZE)) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (win_waddr),
        .i_wdata (win_wdata),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_cnt      = r_cnt;
        n_k        = r_k;
        n_p        = r_p;
        n_psq      = r_psq;
        n_rem      = r_rem;
        n_dq       = r_dq;
        n_dcnt     = r_dcnt;
        n_m        = r_m;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_diff     = r_diff;
        n_ofs      = r_ofs;
        n_v        = r_v;
        n_prev     = r_prev;
        n_pvalid   = r_pvalid;
        n_sgap     = r_sgap;
        n_lgap     = r_lgap;
        n_cf       = r_cf;
        n_cs       = r_cs;
        n_ff       = r_ff;
        n_fs       = r_fs;
        n_pair     = r_pair;
        n_bad      = r_bad;
        n_o_valid  = r_o_valid && i_stall;
        n_o_status = r_o_status;
        n_o_cf     = r_o_cf;
        n_o_cs     = r_o_cs;
        n_o_ff     = r_o_ff;
        n_o_fs     = r_o_fs;
        comp_we    = 1'b0;
        comp_wdata = 1'b0;
        tab_we     = 1'b0;
        tab_wdata  = 16'(r_i);
        win_we     = 1'b0;
        win_wdata  = 1'b0;
        win_waddr  = r_ofs;

        unique case (r_state)
            S_BCLR: begin
                comp_we = 1'b1;
                if (r_j == JW'(BASE_LIMIT)) begin
                    n_state = S_BINIT;
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            S_BINIT: begin
                tab_we    = 1'b1;
                tab_wdata = 16'd2;
                n_cnt     = KW'(1);
                n_i       = IW'(3);
                n_state   = S_BRD;
            end
            S_BRD: begin
                n_state = S_BEV;
            end
            S_BEV: begin
                if (comp_rdata) begin
                    n_i     = i_next;
                    n_state = (i_next > IW'(BASE_LIMIT)) ? S_IDLE : S_BRD;
                end else begin
                    if (r_cnt < KW'(BASE_PRIME_COUNT)) begin
                        tab_we = 1'b1;
                        n_cnt  = r_cnt + KW'(1);
                    end
                    n_state = S_BSQ;
                end
            end
            S_BSQ: begin
                n_j     = JW'(32'(r_i[15:0]) * 32'(r_i[15:0]));
                n_state = S_BMARK;
            end
            S_BMARK: begin
                if (r_j <= JW'(BASE_LIMIT)) begin
                    comp_we    = 1'b1;
                    comp_wdata = 1'b1;
                    n_j        = r_j + JW'({r_i, 1'b0});
                end else begin
                    n_i     = i_next;
                    n_state = (i_next > IW'(BASE_LIMIT)) ? S_IDLE : S_BRD;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_lo     = i_range_low;
                    n_hi     = i_range_high;
                    n_diff   = OFS_W'(q_diff);
                    n_ofs    = '0;
                    n_k      = '0;
                    n_pvalid = 1'b0;
                    n_prev   = '0;
                    n_sgap   = '1;
                    n_lgap   = '0;
                    n_pair   = 1'b0;
                    if (i_range_high < i_range_low || q_diff >= 32'(WINDOW_SIZE)) begin
                        n_bad   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        n_bad   = 1'b0;
                        n_state = S_CLR;
                    end
                end
            end
            S_CLR: begin
                win_we = 1'b1;
                if (r_ofs == r_diff) begin
                    n_state = S_KRD;
                end else begin
                    n_ofs = r_ofs + OFS_W'(1);
                end
            end
            S_KRD: begin
                n_state = S_KEV;
            end
            S_KEV: begin
                n_p = tab_rdata;
                if (tab_rdata < 16'd3) begin
                    n_k = k_next;
                    if (k_next == r_cnt) begin
                        n_v     = r_lo;
                        n_state = S_SRD;
                    end else begin
                        n_state = S_KRD;
                    end
                end else begin
                    n_state = S_KSQ;
                end
            end
            S_KSQ: begin
                n_psq   = 32'(r_p) * 32'(r_p);
                n_state = S_KCHK;
            end
            S_KCHK: begin
                if (r_psq > 32'(r_hi)) begin
                    n_v     = r_lo;
                    n_state = S_SRD;
                end else begin
                    n_rem   = '0;
                    n_dq    = r_lo;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem  = (div_t >= {1'b0, r_p}) ? 16'(div_t - {1'b0, r_p}) : div_t[15:0];
                n_dq   = {r_dq[VAL_W-2:0], 1'b0};
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'(VAL_W - 1)) begin
                    n_state = S_M0;
                end
            end
            S_M0: begin
                n_m     = JW'(r_lo) + ((r_rem != '0) ? JW'(r_p - r_rem) : '0);
                n_state = S_M1;
            end
            S_M1: begin
                if (r_m < JW'(r_psq)) begin
                    n_m = JW'(r_psq);
                end
                n_state = S_M2;
            end
            S_M2: begin
                if (!r_m[0]) begin
                    n_m = r_m + JW'(r_p);
                end
                n_state = S_MARK;
            end
            S_MARK: begin
                if (r_m <= JW'(r_hi)) begin
                    win_we    = 1'b1;
                    win_wdata = 1'b1;
                    win_waddr = m_ofs[OFS_W-1:0];
                    n_m       = r_m + JW'({r_p, 1'b0});
                end else begin
                    n_k = k_next;
                    if (k_next == r_cnt) begin
                        n_v     = r_lo;
                        n_state = S_SRD;
                    end else begin
                        n_state = S_KRD;
                    end
                end
            end
            S_SRD: begin
                n_state = S_SEV;
            end
            S_SEV: begin
                if (is_prime) begin
                    if (r_pvalid) begin
                        n_pair = 1'b1;
                        if (gap > r_lgap) begin
                            n_lgap = gap;
                            n_ff   = r_prev;
                            n_fs   = r_v;
                        end
                        if (gap < r_sgap) begin
                            n_sgap = gap;
                            n_cf   = r_prev;
                            n_cs   = r_v;
                        end
                    end
                    n_prev   = r_v;
                    n_pvalid = 1'b1;
                end
                if (r_v == r_hi) begin
                    n_state = S_DONE;
                end else begin
                    n_v     = r_v + VAL_W'(1);
                    n_state = S_SRD;
                end
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    if (r_bad) begin
                        n_o_status = ST_BAD;
                    end else if (r_pair) begin
                        n_o_status = ST_PAIR;
                    end else begin
                        n_o_status = ST_FEW;
                    end
                    n_o_cf  = (!r_bad && r_pair) ? r_cf : '0;
                    n_o_cs  = (!r_bad && r_pair) ? r_cs : '0;
                    n_o_ff  = (!r_bad && r_pair) ? r_ff : '0;
                    n_o_fs  = (!r_bad && r_pair) ? r_fs : '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_BCLR;
            r_j       <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_j       <= n_j;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
        r_i        <= n_i;
        r_k        <= n_k;
        r_p        <= n_p;
        r_psq      <= n_psq;
        r_rem      <= n_rem;
        r_dq       <= n_dq;
        r_dcnt     <= n_dcnt;
        r_m        <= n_m;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_diff     <= n_diff;
        r_ofs      <= n_ofs;
        r_v        <= n_v;
        r_prev     <= n_prev;
        r_pvalid   <= n_pvalid;
        r_sgap     <= n_sgap;
        r_lgap     <= n_lgap;
        r_cf       <= n_cf;
        r_cs       <= n_cs;
        r_ff       <= n_ff;
        r_fs       <= n_fs;
        r_pair     <= n_pair;
        r_bad      <= n_bad;
        r_o_status <= n_o_status;
        r_o_cf     <= n_o_cf;
        r_o_cs     <= n_o_cs;
        r_o_ff     <= n_o_ff;
        r_o_fs     <= n_o_fs;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_close_first  = r_o_cf;
    assign o_close_second = r_o_cs;
    assign o_far_first    = r_o_ff;
    assign o_far_second   = r_o_fs;

    `ASSERT_PROP(a_cnt_bound, i_clk, i_rst_n, r_cnt <= KW'(BASE_PRIME_COUNT))
    `ASSERT_PROP(a_bad_zero, i_clk, i_rst_n,
        (r_o_valid && r_o_status == ST_BAD) |-> (r_o_cf == '0 && r_o_fs == '0))
    `ASSERT_PROP(a_scan_range, i_clk, i_rst_n, (r_state == S_SEV) |-> (r_v >= r_lo && r_v <= r_hi))
    `ASSERT_NEVER(a_mark_out, i_clk, i_rst_n, win_we && win_wdata && (m_ofs > JW'(r_diff)))
endmodule
